// ===== src/bqct_pkg.sv =====
// Package: shared types and constants of the bracket, quote and comment tracker.
`default_nettype none

package bqct_pkg;

  // Characters that the tracker reacts to.
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_LSQUARE   = 8'h5B;
  localparam logic [7:0] CH_RSQUARE   = 8'h5D;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;

  // Most innermost opens that a result beat can carry.
  localparam int WIN_SIZE = 4;

  typedef enum logic [1:0] {
    DELIM_PAREN  = 2'd0,
    DELIM_SQUARE = 2'd1,
    DELIM_BRACE  = 2'd2
  } delim_t;

  typedef enum logic [2:0] {
    MODE_NONE     = 3'd0,
    MODE_STRING   = 3'd1,
    MODE_CHAR     = 3'd2,
    MODE_BLOCK    = 3'd3,
    MODE_BRACKETS = 3'd4
  } mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       start_flag;
  } text_t;

  typedef struct packed {
    logic [2:0]  open_mode;
    logic [15:0] open_count;
    logic        balanced;
    logic [2:0]  shown_count;
    logic [1:0]  shown_first;
    logic [1:0]  shown_second;
    logic [1:0]  shown_third;
    logic [1:0]  shown_fourth;
  } result_t;

endpackage

`default_nettype wire

// ===== src/bqct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bqct_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/bracket_quote_comment_tracker.sv =====
// Top level: byte-stream bracket, quote and comment tracker.
// Result: a result beat is registered and appears in the cycle after its text beat is accepted.
// Throughput: one text beat per cycle while the result side is not stalled; the combinational
//   update of the mode flags, the bracket count and the four-entry window of innermost opens sets that rate.
// Reset (rst, synchronous): clears all mode flags, the count and the result valid;
//   the open-bracket RAM is not cleared and needs no clearing pass.
`default_nettype none

module bracket_quote_comment_tracker #(
  parameter int STACK_DEPTH  = 64,
  parameter int SHOWN_DELIMS = 4,
  parameter int COUNT_WIDTH  = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              text_valid,
  output logic                   text_ready,
  input  wire bqct_pkg::text_t   text,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output bqct_pkg::result_t      result
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  // The stored count runs from zero up to STACK_DEPTH inclusive.
  localparam int SW = $clog2(STACK_DEPTH + 1);
  localparam int SHOWN_LIM = (SHOWN_DELIMS < bqct_pkg::WIN_SIZE) ? SHOWN_DELIMS
                                                                  : bqct_pkg::WIN_SIZE;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Mode flags and the pending flags that stand in for one byte of lookahead.
  logic in_string, in_charlit, in_block_comment, in_line_comment;
  logic escape_pending, slash_pending, star_pending;
  logic [COUNT_WIDTH-1:0] depth;
  // Number of opens held in the RAM: always the smaller of depth and STACK_DEPTH.
  logic [SW-1:0] stored;
  // The innermost stored opens; window[0] is the top of the stack.
  logic [1:0] window [bqct_pkg::WIN_SIZE];

  logic in_string_next, in_charlit_next, in_block_comment_next, in_line_comment_next;
  logic escape_pending_next, slash_pending_next, star_pending_next;
  logic [COUNT_WIDTH-1:0] depth_next;
  logic [SW-1:0] stored_next;
  logic [1:0] window_next [bqct_pkg::WIN_SIZE];

  logic accept;
  logic push, pop;
  logic [1:0] push_code;
  logic [1:0] ram_rdata;
  logic [SW-1:0] rd_stored;
  logic [SW-1:0] rd_sub;
  logic [SW-1:0] shown_k;
  logic [2:0] shown_k3;
  logic [1:0] shown [bqct_pkg::WIN_SIZE];
  bqct_pkg::result_t result_next;
  bqct_pkg::mode_t mode;

  // The result register parts the two sides: a new beat is taken whenever the
  // held result is empty or leaves in this same cycle.
  assign text_ready = !result_valid || result_ready;
  assign accept     = text_valid && text_ready;

  // Next-state logic. A start flag clears the state before the byte is handled,
  // so every "current" value below is seen through that clear.
  always_comb begin
    logic       c_str, c_chr, c_blk, c_line, c_esc, c_slash, c_star;
    logic [COUNT_WIDTH-1:0] c_depth;
    logic [SW-1:0] c_stored;
    logic [7:0] c;
    logic       do_plain;

    c        = text.text_byte;
    c_str    = in_string        && !text.start_flag;
    c_chr    = in_charlit       && !text.start_flag;
    c_blk    = in_block_comment && !text.start_flag;
    c_line   = in_line_comment  && !text.start_flag;
    c_esc    = escape_pending   && !text.start_flag;
    c_slash  = slash_pending    && !text.start_flag;
    c_star   = star_pending     && !text.start_flag;
    c_depth  = text.start_flag ? '0 : depth;
    c_stored = text.start_flag ? '0 : stored;

    in_string_next        = c_str;
    in_charlit_next       = c_chr;
    in_block_comment_next = c_blk;
    in_line_comment_next  = c_line;
    escape_pending_next   = c_esc;
    slash_pending_next    = c_slash;
    star_pending_next     = c_star;
    depth_next            = c_depth;
    stored_next           = c_stored;
    do_plain              = 1'b0;
    push                  = 1'b0;
    pop                   = 1'b0;
    push_code             = bqct_pkg::DELIM_PAREN;

    if (c_blk) begin
      if (c_star && c == bqct_pkg::CH_SLASH) begin
        in_block_comment_next = 1'b0;
        star_pending_next     = 1'b0;
      end else begin
        star_pending_next = (c == bqct_pkg::CH_STAR);
      end
    end else if (c_str || c_chr) begin
      if (c_esc) begin
        escape_pending_next = 1'b0;
      end else if (c == bqct_pkg::CH_BACKSLASH) begin
        escape_pending_next = 1'b1;
      end else if (c_str && c == bqct_pkg::CH_DQUOTE) begin
        in_string_next = 1'b0;
      end else if (c_chr && c == bqct_pkg::CH_SQUOTE) begin
        in_charlit_next = 1'b0;
      end
    end else if (c_line) begin
      if (c == bqct_pkg::CH_NEWLINE) begin
        in_line_comment_next = 1'b0;
      end
    end else if (c_slash) begin
      slash_pending_next = 1'b0;
      if (c == bqct_pkg::CH_SLASH) begin
        in_line_comment_next = 1'b1;
      end else if (c == bqct_pkg::CH_STAR) begin
        in_block_comment_next = 1'b1;
        star_pending_next     = 1'b0;
      end else begin
        do_plain = 1'b1;
      end
    end else begin
      do_plain = 1'b1;
    end

    if (do_plain) begin
      if (c == bqct_pkg::CH_SLASH) begin
        slash_pending_next = 1'b1;
      end else if (c == bqct_pkg::CH_DQUOTE) begin
        in_string_next      = 1'b1;
        escape_pending_next = 1'b0;
      end else if (c == bqct_pkg::CH_SQUOTE) begin
        in_charlit_next     = 1'b1;
        escape_pending_next = 1'b0;
      end else if (c == bqct_pkg::CH_LPAREN || c == bqct_pkg::CH_LSQUARE ||
                   c == bqct_pkg::CH_LBRACE) begin
        // A saturated count takes no further opens; opens past the RAM are
        // counted only.
        if (c_depth != COUNT_MAX) begin
          depth_next = c_depth + 1'b1;
          if (32'(c_depth) < 32'(STACK_DEPTH)) begin
            push        = 1'b1;
            stored_next = c_stored + 1'b1;
          end
        end
        if (c == bqct_pkg::CH_LPAREN) begin
          push_code = bqct_pkg::DELIM_PAREN;
        end else if (c == bqct_pkg::CH_LSQUARE) begin
          push_code = bqct_pkg::DELIM_SQUARE;
        end else begin
          push_code = bqct_pkg::DELIM_BRACE;
        end
      end else if (c == bqct_pkg::CH_RPAREN || c == bqct_pkg::CH_RSQUARE ||
                   c == bqct_pkg::CH_RBRACE) begin
        // A closer at depth zero is ignored; one above the stored opens only
        // lowers the count.
        if (c_depth != '0) begin
          depth_next = c_depth - 1'b1;
          if (32'(c_depth) <= 32'(STACK_DEPTH)) begin
            pop         = 1'b1;
            stored_next = c_stored - 1'b1;
          end
        end
      end
    end
  end

  // Window update. On a pop the entry that slides in at the bottom comes from
  // the RAM, whose registered read was issued in the previous cycle at stored - 5 (one below the
  // window), so it is ready whenever the pop comes.
  always_comb begin
    for (int j = 0; j < bqct_pkg::WIN_SIZE; j++) begin
      window_next[j] = window[j];
    end
    if (push) begin
      window_next[0] = push_code;
      for (int j = 1; j < bqct_pkg::WIN_SIZE; j++) begin
        window_next[j] = window[j-1];
      end
    end else if (pop) begin
      for (int j = 0; j < bqct_pkg::WIN_SIZE - 1; j++) begin
        window_next[j] = window[j+1];
      end
      window_next[bqct_pkg::WIN_SIZE-1] = ram_rdata;
    end
  end

  // Read address for the next cycle, from the stored count that the next cycle
  // will see. Below five stored opens the address is unused.
  assign rd_stored = accept ? stored_next : stored;
  assign rd_sub    = rd_stored - SW'(bqct_pkg::WIN_SIZE + 1);

  bqct_ram #(
    .WIDTH (2),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (accept && push),
    .waddr (text.start_flag ? '0 : stored[AW-1:0]),
    .wdata (push_code),
    .raddr (rd_sub[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Result beat, built from the state after this byte.
  always_comb begin
    if (in_string_next) begin
      mode = bqct_pkg::MODE_STRING;
    end else if (in_charlit_next) begin
      mode = bqct_pkg::MODE_CHAR;
    end else if (in_block_comment_next) begin
      mode = bqct_pkg::MODE_BLOCK;
    end else if (depth_next != '0) begin
      mode = bqct_pkg::MODE_BRACKETS;
    end else begin
      mode = bqct_pkg::MODE_NONE;
    end
  end

  assign shown_k  = (stored_next < SW'(SHOWN_LIM)) ? stored_next : SW'(SHOWN_LIM);
  assign shown_k3 = 3'(shown_k);

  // Oldest shown open goes first; places past the shown count read as zero.
  always_comb begin
    for (int i = 0; i < bqct_pkg::WIN_SIZE; i++) begin
      if (3'(i) < shown_k3) begin
        shown[i] = window_next[2'(shown_k3 - 3'(i) - 3'd1)];
      end else begin
        shown[i] = bqct_pkg::DELIM_PAREN;
      end
    end
  end

  always_comb begin
    result_next.open_mode    = mode;
    result_next.open_count   = 16'(depth_next);
    result_next.balanced     = (mode == bqct_pkg::MODE_NONE);
    result_next.shown_count  = shown_k3;
    result_next.shown_first  = shown[0];
    result_next.shown_second = shown[1];
    result_next.shown_third  = shown[2];
    result_next.shown_fourth = shown[3];
  end

  // Tracker state advances only on an accepted text beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_string        <= 1'b0;
      in_charlit       <= 1'b0;
      in_block_comment <= 1'b0;
      in_line_comment  <= 1'b0;
      escape_pending   <= 1'b0;
      slash_pending    <= 1'b0;
      star_pending     <= 1'b0;
      depth            <= '0;
      stored           <= '0;
    end else if (accept) begin
      in_string        <= in_string_next;
      in_charlit       <= in_charlit_next;
      in_block_comment <= in_block_comment_next;
      in_line_comment  <= in_line_comment_next;
      escape_pending   <= escape_pending_next;
      slash_pending    <= slash_pending_next;
      star_pending     <= star_pending_next;
      depth            <= depth_next;
      stored           <= stored_next;
    end
  end

  // The window is payload: its entries past the stored count are never shown.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < bqct_pkg::WIN_SIZE; j++) begin
        window[j] <= window_next[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  // The stored count must track the bracket count, capped at the RAM depth.
  a_stored_tracks_depth: assert property (@(posedge clk) disable iff (rst)
    (32'(depth) < 32'(STACK_DEPTH)) ? (32'(stored) == 32'(depth))
                                    : (32'(stored) == 32'(STACK_DEPTH)))
    else $error("stored count out of step with bracket count");

  // A string and a char literal can never be open together.
  a_one_literal: assert property (@(posedge clk) disable iff (rst)
    !(in_string && in_charlit))
    else $error("string and char literal open at once");

  // Every accepted text beat leaves a result beat behind it.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("accepted beat produced no result");

  // The shown count never exceeds the window size, and balanced matches an open mode of none.
  a_shown_bounded: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (32'(result.shown_count) <= 32'(bqct_pkg::WIN_SIZE)) &&
                     (result.balanced == (result.open_mode == bqct_pkg::MODE_NONE)))
    else $error("result beat inconsistent");
`endif

endmodule

`default_nettype wire
